/* sv/sida_pkg.sv */
// Shared types, constants and helpers for the signed decimal ASCII printer.
`timescale 1ns / 1ps

package sida_pkg;

    // ASCII codes used on the character output
    localparam logic [6:0] ASCII_ZERO  = 7'd48;
    localparam logic [6:0] ASCII_MINUS = 7'd45;

    // Sequencer states of the top level
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_EMIT
    } seq_state_t;

    // Commands from the sequencer to the BCD converter
    typedef struct packed {
        logic load;       // start a new conversion from the magnitude
        logic shift_out;  // drop the top BCD digit, move the rest up
    } bcd_ctrl_t;

    // Status from the BCD converter to the sequencer
    typedef struct packed {
        logic done;       // conversion finished, digits are valid
    } bcd_stat_t;

    // Shift-add-3 correction of one BCD digit
    function automatic logic [3:0] bcd_adjust(input logic [3:0] d);
        logic [3:0] r;
        r = (d >= 4'd5) ? (d + 4'd3) : d;
        return r;
    endfunction

endpackage

/* sv/sida_bcd_conv.sv */
// Bit-serial binary to BCD converter (shift-add-3) with a digit shift-out path.
`timescale 1ns / 1ps

module sida_bcd_conv #(
    parameter int VALUE_BITS = 32,
    parameter int NDIG       = 10
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sida_pkg::bcd_ctrl_t     ctrl,
    input  logic [VALUE_BITS-1:0]   mag,
    output sida_pkg::bcd_stat_t     stat,
    output logic [3:0]              top_digit
);
    import sida_pkg::*;

    localparam int CW = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] bin_reg;
    logic [VALUE_BITS-1:0] bin_next;
    logic [4*NDIG-1:0]     bcd_reg;
    logic [4*NDIG-1:0]     bcd_next;
    logic [4*NDIG-1:0]     bcd_adj;
    logic [CW-1:0]         cnt_reg;
    logic [CW-1:0]         cnt_next;
    logic                  busy_reg;
    logic                  busy_next;

    // Correct every digit before the shift; digits are independent lanes
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            bcd_adj[4*i +: 4] = bcd_adjust(bcd_reg[4*i +: 4]);
        end
    end

    // Load, shift one bit in per cycle, or shift a finished digit out
    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        priority if (ctrl.load)
        begin
            bin_next  = mag;
            bcd_next  = '0;
            cnt_next  = CW'(VALUE_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bin_next = {bin_reg[VALUE_BITS-2:0], 1'b0};
            bcd_next = {bcd_adj[4*NDIG-2:0], bin_reg[VALUE_BITS-1]};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
        else if (ctrl.shift_out)
        begin
            bcd_next = {bcd_reg[4*NDIG-5:0], 4'd0};
        end
        else
        begin
            // Hold everything
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold the data shift registers
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign stat.done = !busy_reg;
    assign top_digit = bcd_reg[4*NDIG-1 -: 4];

`ifndef SYNTHESIS
    // A load always starts a conversion
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |=> busy_reg)
        else $error("converter not busy after load");

    // The bit counter is nonzero while converting
    a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != '0))
        else $error("converter busy with empty bit count");

    // The top BCD digit is a decimal digit after a finished conversion
    a_top_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy_reg && $past(busy_reg)) |-> (top_digit <= 4'd9))
        else $error("top BCD digit out of range");
`endif

endmodule

/* sv/signed_int_to_decimal_ascii_core.sv */
// Signed integer to decimal ASCII printer: top level and character sequencer.
`timescale 1ns / 1ps

// Takes one signed VALUE_BITS-bit integer per item and prints it in decimal as
// a run of ASCII characters, most significant digit first, one character per
// result item: '-' first for a negative value, then the digits, with
// last_char set on the final digit. The most negative value prints exactly
// and zero prints a single '0'. One item is worked on at a time: after
// acceptance the magnitude is converted to BCD one bit per cycle by the
// bit-serial shift-add-3 converter, then leading zero digits are dropped one
// per cycle and the characters leave one per cycle while the output does not
// stall. A finished character sits in an output register, so a stalled
// output only holds the sequencer.

module signed_int_to_decimal_ascii_core #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [6:0]            char_code,
    output logic                  last_char
);
    import sida_pkg::*;

    // Decimal digits needed for a VALUE_BITS-bit unsigned magnitude
    localparam int NDIG = (VALUE_BITS * 1233) / 4096 + 1;
    localparam int DCW  = $clog2(NDIG + 1);

    seq_state_t            state_reg;
    seq_state_t            state_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic                  started_reg;
    logic                  started_next;
    logic [DCW-1:0]        dig_left_reg;
    logic [DCW-1:0]        dig_left_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [6:0]            char_reg;
    logic [6:0]            char_next;
    logic                  last_reg;
    logic                  last_next;

    logic                  in_accept;
    logic                  out_free;
    logic                  skip_zero;
    logic                  emit;
    logic                  emit_char;
    logic                  emit_last;
    logic [6:0]            emit_code;
    logic [VALUE_BITS-1:0] mag;
    bcd_ctrl_t             bcd_ctrl;
    bcd_stat_t             bcd_stat;
    logic [3:0]            top_digit;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Unsigned magnitude; the most negative value maps onto 2^(VALUE_BITS-1)
    assign mag = value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;

    // Drop a leading zero while digits remain behind it
    assign skip_zero = !started_reg && (top_digit == 4'd0) && (dig_left_reg > DCW'(1));

    sida_bcd_conv #(
        .VALUE_BITS (VALUE_BITS),
        .NDIG       (NDIG)
    ) u_bcd (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (bcd_ctrl),
        .mag       (mag),
        .stat      (bcd_stat),
        .top_digit (top_digit)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (bcd_stat.done)
                begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!skip_zero && out_free && (dig_left_reg == DCW'(1)))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: converter commands and the character to emit
    always_comb
    begin
        bcd_ctrl.load      = 1'b0;
        bcd_ctrl.shift_out = 1'b0;
        emit_char          = 1'b0;
        emit_code          = ASCII_ZERO + {3'd0, top_digit};
        emit_last          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                bcd_ctrl.load = in_accept;
            end
            ST_CONV:
            begin
            end
            ST_SIGN:
            begin
                emit_char = out_free;
                emit_code = ASCII_MINUS;
            end
            ST_EMIT:
            begin
                if (skip_zero)
                begin
                    bcd_ctrl.shift_out = 1'b1;
                end
                else if (out_free)
                begin
                    bcd_ctrl.shift_out = 1'b1;
                    emit_char          = 1'b1;
                    emit_last          = (dig_left_reg == DCW'(1));
                end
            end
            default:
            begin
            end
        endcase
    end

    assign emit = emit_char;

    // Advance item bookkeeping and the output register
    always_comb
    begin
        neg_next       = neg_reg;
        started_next   = started_reg;
        dig_left_next  = dig_left_reg;
        out_valid_next = out_valid_reg && out_stall;
        char_next      = char_reg;
        last_next      = last_reg;
        if (in_accept)
        begin
            neg_next      = value[VALUE_BITS-1];
            started_next  = 1'b0;
            dig_left_next = DCW'(NDIG);
        end
        if (bcd_ctrl.shift_out)
        begin
            dig_left_next = dig_left_reg - DCW'(1);
        end
        if (emit && (state_reg == ST_EMIT))
        begin
            started_next = 1'b1;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            char_next      = emit_code;
            last_next      = emit_last;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            neg_reg       <= 1'b0;
            started_reg   <= 1'b0;
            dig_left_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            neg_reg       <= neg_next;
            started_reg   <= started_next;
            dig_left_reg  <= dig_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the output payload
    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;

`ifndef SYNTHESIS
    // An accepted item always starts a conversion
    a_accept_conv: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_CONV))
        else $error("accepted item did not enter conversion");

    // The converter is idle whenever no item is in work
    a_idle_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> bcd_stat.done)
        else $error("converter busy while sequencer idle");

    // The last character of a run returns the sequencer to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_last) |=> (state_reg == ST_IDLE))
        else $error("sequencer not idle after last character");

    // A minus sign never closes a run
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (char_reg == ASCII_MINUS)) |-> !last_reg)
        else $error("minus sign flagged as last character");

    // Digits remain to be printed while emitting
    a_digits_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (dig_left_reg != '0))
        else $error("emitting with no digits left");
`endif

endmodule

/* test/tb_signed_int_to_decimal_ascii_core.sv */
// Testbench for the signed integer to decimal ASCII printer.
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii_core;
    import sida_pkg::*;

    localparam int VALUE_BITS   = 32;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int SETTLE_TICKS = 80;
    localparam int HOLD_TICKS   = 400;
    localparam int NDIR         = 20;
    localparam int PHASE_ITEMS  = 20;

    // One printed character as it leaves the block
    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } ascii_char_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [VALUE_BITS-1:0] value = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [6:0]            char_code;
    logic                  last_char;

    ascii_char_t pending_chars[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          output_hold = 1'b0;

    // Directed rows: an empty string means the text comes from the predictor
    logic [VALUE_BITS-1:0] dir_value [NDIR] = '{
        32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
        32'd2147483647, 32'h80000000, 32'h80000001, 32'd1000000000,
        32'd999999999, -32'sd1000000000, 32'd12345, -32'sd98765,
        32'h55555555, 32'hAAAAAAAA, 32'd1999999999, 32'd42
    };
    string dir_text [NDIR] = '{
        "0", "1", "-1", "9", "10", "-10", "99", "100",
        "2147483647", "-2147483648", "-2147483647", "1000000000",
        "999999999", "-1000000000", "", "",
        "", "", "", ""
    };

    signed_int_to_decimal_ascii_core #(
        .VALUE_BITS(VALUE_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .last_char (last_char)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Queue the characters of the decimal text of one value
    function automatic void predict_decimal(input logic [VALUE_BITS-1:0] v);
        logic [VALUE_BITS-1:0] mag;
        logic [3:0]            digits[$];
        logic                  negative;
        negative = v[VALUE_BITS-1];
        mag = negative ? -v : v;
        do
        begin
            digits.push_front(4'(mag % 10));
            mag = mag / 10;
        end
        while (mag != 0);
        if (negative)
            pending_chars.push_back('{code: ASCII_MINUS, last: 1'b0});
        foreach (digits[i])
            pending_chars.push_back('{code: ASCII_ZERO + 7'(digits[i]),
                                      last: (i == digits.size() - 1)});
    endfunction

    // Queue characters typed in as a string
    function automatic void queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            pending_chars.push_back('{code: 7'(s[i]), last: (i == s.len() - 1)});
    endfunction

    // Random value: full range, a chosen digit count, values around powers of ten, or extremes
    function automatic logic [VALUE_BITS-1:0] pick_value();
        longint lo;
        longint hi;
        longint mag;
        int     sel;
        int     ndig;
        sel = $urandom_range(9);
        ndig = $urandom_range(1, 10);
        lo = 1;
        repeat (ndig - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        if (hi > 64'd2147483648)
            hi = 64'd2147483648;
        if (ndig == 1)
            lo = 0;
        if (sel <= 2)
            return $urandom();
        else if (sel <= 6)
            mag = lo + (longint'($urandom()) % (hi - lo + 1));
        else if (sel <= 8)
            mag = (ndig == 1 ? 1 : lo) + $urandom_range(2) - 1;
        else
        begin
            case ($urandom_range(3))
                0: return 32'h7FFFFFFF;
                1: return 32'h80000000;
                2: return 32'h80000001;
                default: return 32'h7FFFFFFE;
            endcase
        end
        if ($urandom_range(1))
            mag = -mag;
        return mag[VALUE_BITS-1:0];
    endfunction

    // Offer one item, wait for acceptance, then queue its characters
    task automatic send_item(input logic [VALUE_BITS-1:0] v, input string text);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        if (text.len() != 0)
            queue_text(text);
        else
            predict_decimal(v);
    endtask

    // Drop the offer and wait for every queued character
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
    endtask

    // Hold the output stalled for a long stretch
    task automatic hold_output(input int ticks);
        output_hold = 1'b1;
        repeat (ticks) @(posedge clk);
        output_hold = 1'b0;
    endtask

    // Drive the output stall
    always @(posedge clk)
        out_stall <= output_hold || ($urandom_range(99) < recv_stall_pct);

    // Check each character as it is accepted
    always @(negedge clk)
    begin
        ascii_char_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_chars.size() == 0)
            begin
                $error("unexpected item: char_code %0d last_char %0d", char_code, last_char);
                error_count++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (char_code !== want.code)
                begin
                    $error("char_code: expected %0d, got %0d", want.code, char_code);
                    error_count++;
                end
                if (last_char !== want.last)
                begin
                    $error("last_char: expected %0d, got %0d", want.last, last_char);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        int idle_pct [4];
        int stall_pct [4];
        idle_pct  = '{0, 84, 0, 16};
        stall_pct = '{0, 0, 84, 16};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (int i = 0; i < NDIR; i++)
            send_item(dir_value[i], dir_text[i]);
        drain();

        // Fill the block while the output is held off
        fork
            hold_output(HOLD_TICKS);
        join_none
        for (int i = 0; i < 8; i++)
            send_item(pick_value(), "");
        drain();

        // Random items under each idling mix
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = idle_pct[p];
            recv_stall_pct = stall_pct[p];
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_item(pick_value(), "");
            drain();
        end

        in_valid <= 1'b0;
        recv_stall_pct = 0;
        drain();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (pending_chars.size() == 0 && error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* signed_int_to_decimal_ascii_core.f */
sv/sida_pkg.sv
sv/sida_bcd_conv.sv
sv/signed_int_to_decimal_ascii_core.sv
test/tb_signed_int_to_decimal_ascii_core.sv
